>>> hdl/fblc_pkg.sv
// Package for the FAT16 boot layout calculator: constants, status codes and stage types.
package fblc_pkg;

  localparam logic [15:0] SIG_WORD           = 16'hAA55;
  localparam logic [39:0] TYPE_FAT16         = 40'h3631544146;
  localparam int unsigned DIR_ENTRY_LEN      = 32;
  localparam int unsigned DIV_BITS_PER_STAGE = 4;

  typedef enum logic [1:0] {
    ST_VALID      = 2'd0,
    ST_NOT_FAT16  = 2'd1,
    ST_BAD_LAYOUT = 2'd2
  } status_e;

  // carried alongside the root-span divider
  typedef struct packed {
    logic        bad;
    logic [31:0] total;
    logic [23:0] rstart;
    logic [15:0] sb;
    logic [7:0]  cs;
    logic [15:0] res;
  } side1_t;

  // carried alongside the cluster-count divider
  typedef struct packed {
    status_e     status;
    logic [31:0] total;
    logic [20:0] span;
    logic [15:0] res;
    logic [23:0] rstart;
    logic [24:0] dstart;
    logic [31:0] fbo;
    logic [39:0] rbo;
    logic [40:0] dbo;
    logic [23:0] cb;
  } side2_t;

endpackage

>>> hdl/fblc_div.sv
// Pipelined restoring divider, BitsPerStage quotient bits per stage, with a sideband carried along.
module fblc_div
  import fblc_pkg::*;
#(
  parameter int unsigned NumW         = 32,
  parameter int unsigned DenW         = 8,
  parameter int unsigned SideW        = 1,
  parameter int unsigned BitsPerStage = DIV_BITS_PER_STAGE
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [NumW-1:0]  quo_o,
  output logic [DenW-1:0]  rem_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned NumStages = (NumW + BitsPerStage - 1) / BitsPerStage;

  logic             vld_q  [NumStages];
  logic [NumW-1:0]  acc_q  [NumStages];
  logic [DenW-1:0]  rem_q  [NumStages];
  logic [DenW-1:0]  den_q  [NumStages];
  logic [SideW-1:0] side_q [NumStages];

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic             vld_in;
    logic [NumW-1:0]  acc_in;
    logic [DenW-1:0]  rem_in;
    logic [DenW-1:0]  den_in;
    logic [SideW-1:0] side_in;
    logic [NumW-1:0]  acc_d;
    logic [DenW-1:0]  rem_d;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign acc_in  = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign acc_in  = acc_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      logic [DenW:0] trial;
      acc_d = acc_in;
      rem_d = rem_in;
      trial = '0;
      for (int k = 0; k < BitsPerStage; k++) begin
        if (s * BitsPerStage + k < NumW) begin
          trial = {rem_d, acc_d[NumW-1]};
          if (trial >= {1'b0, den_in}) begin
            trial = trial - {1'b0, den_in};
            acc_d = {acc_d[NumW-2:0], 1'b1};
          end else begin
            acc_d = {acc_d[NumW-2:0], 1'b0};
          end
          rem_d = trial[DenW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      acc_q[s]  <= acc_d;
      rem_q[s]  <= rem_d;
      den_q[s]  <= den_in;
      side_q[s] <= side_in;
    end
  end

  assign vld_o  = vld_q[NumStages-1];
  assign quo_o  = acc_q[NumStages-1];
  assign rem_o  = rem_q[NumStages-1];
  assign side_o = side_q[NumStages-1];

endmodule

>>> hdl/fat16_boot_layout_calc_top.sv
// Top level of the FAT16 boot layout calculator.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  item in  | start_i high, busy_o low | signature_i .. type_text_i
//  result   | done_o strobe, 1 cycle   | status_o .. cluster_total_o
//
// Fully pipelined: one item may enter every cycle, busy_o stays low.
// An item passes stage A, the root span divider, stages C to E, the cluster count
// divider and the output register; divider depth is set by DivBitsPerStage.
// Reset clears only the valid bits; nothing is in flight afterwards.
// The receiver cannot stall, so the pipeline never holds.
module fat16_boot_layout_calc_top
  import fblc_pkg::*;
#(
  parameter int unsigned DivBitsPerStage = DIV_BITS_PER_STAGE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] signature_i,
  input  logic [15:0] sector_bytes_i,
  input  logic [7:0]  cluster_sectors_i,
  input  logic [15:0] reserved_count_i,
  input  logic [7:0]  fat_copies_i,
  input  logic [15:0] fat_sectors_i,
  input  logic [15:0] root_entries_i,
  input  logic [15:0] total_small_i,
  input  logic [31:0] total_large_i,
  input  logic [39:0] type_text_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] sector_total_o,
  output logic [20:0] root_span_o,
  output logic [15:0] fat_start_o,
  output logic [23:0] root_start_o,
  output logic [24:0] data_start_o,
  output logic [31:0] fat_byte_offset_o,
  output logic [39:0] root_byte_offset_o,
  output logic [40:0] data_byte_offset_o,
  output logic [23:0] cluster_bytes_o,
  output logic [31:0] cluster_total_o
);

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // stage A: checks, total select, products
  logic        a_vld_q;
  logic        a_bad_q, a_bad_d;
  logic [31:0] a_total_q;
  logic [20:0] a_num_q;
  logic [23:0] a_fprod_q;
  logic [15:0] a_sb_q, a_res_q;
  logic [7:0]  a_cs_q;

  assign a_bad_d = (signature_i != SIG_WORD) || (sector_bytes_i == '0) ||
                   (cluster_sectors_i == '0) || (fat_copies_i == '0) ||
                   (fat_sectors_i == '0) || (root_entries_i == '0) ||
                   (type_text_i != TYPE_FAT16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    a_bad_q   <= a_bad_d;
    a_total_q <= (total_small_i != '0) ? 32'(total_small_i) : total_large_i;
    a_num_q   <= 21'(root_entries_i) * 21'(DIR_ENTRY_LEN);
    a_fprod_q <= 24'(fat_copies_i) * 24'(fat_sectors_i);
    a_sb_q    <= sector_bytes_i;
    a_res_q   <= reserved_count_i;
    a_cs_q    <= cluster_sectors_i;
  end

  // root span divider
  side1_t      s1_in, s1_out;
  logic        v1_out;
  logic [20:0] q1;
  logic [15:0] r1;
  logic [$bits(side1_t)-1:0] s1_bits;

  assign s1_in.bad    = a_bad_q;
  assign s1_in.total  = a_total_q;
  assign s1_in.rstart = 24'(a_res_q) + a_fprod_q;
  assign s1_in.sb     = a_sb_q;
  assign s1_in.cs     = a_cs_q;
  assign s1_in.res    = a_res_q;

  fblc_div #(
    .NumW        (21),
    .DenW        (16),
    .SideW       ($bits(side1_t)),
    .BitsPerStage(DivBitsPerStage)
  ) u_div_span (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (a_vld_q),
    .num_i  (a_num_q),
    .den_i  (a_sb_q),
    .side_i (s1_in),
    .vld_o  (v1_out),
    .quo_o  (q1),
    .rem_o  (r1),
    .side_o (s1_bits)
  );
  assign s1_out = side1_t'(s1_bits);

  // stage C: round span up
  logic        c_vld_q;
  side1_t      c_side_q;
  logic [20:0] c_span_q;

  // stage D: data start
  logic        d_vld_q;
  side1_t      d_side_q;
  logic [20:0] d_span_q;
  logic [24:0] d_dstart_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      c_vld_q <= v1_out;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_side_q   <= s1_out;
    c_span_q   <= q1 + 21'(r1 != '0);
    d_side_q   <= c_side_q;
    d_span_q   <= c_span_q;
    d_dstart_q <= 25'(c_side_q.rstart) + 25'(c_span_q);
  end

  // stage E: status, cluster-area size, byte offsets
  logic        e_vld_q;
  side2_t      e_side_q, e_side_d;
  logic [31:0] e_diff_q;
  logic [7:0]  e_cs_q;

  always_comb begin
    if (d_side_q.bad) begin
      e_side_d.status = ST_NOT_FAT16;
    end else if (d_side_q.total <= 32'(d_dstart_q)) begin
      e_side_d.status = ST_BAD_LAYOUT;
    end else begin
      e_side_d.status = ST_VALID;
    end
    e_side_d.total  = d_side_q.total;
    e_side_d.span   = d_span_q;
    e_side_d.res    = d_side_q.res;
    e_side_d.rstart = d_side_q.rstart;
    e_side_d.dstart = d_dstart_q;
    e_side_d.fbo    = 32'(d_side_q.res) * 32'(d_side_q.sb);
    e_side_d.rbo    = 40'(d_side_q.rstart) * 40'(d_side_q.sb);
    e_side_d.dbo    = 41'(d_dstart_q) * 41'(d_side_q.sb);
    e_side_d.cb     = 24'(d_side_q.sb) * 24'(d_side_q.cs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_side_q <= e_side_d;
    e_diff_q <= d_side_q.total - 32'(d_dstart_q);
    e_cs_q   <= d_side_q.cs;
  end

  // cluster count divider
  side2_t      s2_out;
  logic        v2_out;
  logic [31:0] q2;
  logic [7:0]  r2;
  logic [$bits(side2_t)-1:0] s2_bits;

  fblc_div #(
    .NumW        (32),
    .DenW        (8),
    .SideW       ($bits(side2_t)),
    .BitsPerStage(DivBitsPerStage)
  ) u_div_clus (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (e_vld_q),
    .num_i  (e_diff_q),
    .den_i  (e_cs_q),
    .side_i (e_side_q),
    .vld_o  (v2_out),
    .quo_o  (q2),
    .rem_o  (r2),
    .side_o (s2_bits)
  );
  assign s2_out = side2_t'(s2_bits);

  // output register, fields zeroed unless the status is valid
  logic        done_q;
  logic [1:0]  status_q;
  logic [31:0] sector_total_q, fat_byte_offset_q, cluster_total_q;
  logic [20:0] root_span_q;
  logic [15:0] fat_start_q;
  logic [23:0] root_start_q, cluster_bytes_q;
  logic [24:0] data_start_q;
  logic [39:0] root_byte_offset_q;
  logic [40:0] data_byte_offset_q;
  logic        ok;
  logic        unused_rem;

  assign ok         = (s2_out.status == ST_VALID);
  assign unused_rem = ^r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v2_out;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q           <= s2_out.status;
    sector_total_q     <= ok ? s2_out.total  : '0;
    root_span_q        <= ok ? s2_out.span   : '0;
    fat_start_q        <= ok ? s2_out.res    : '0;
    root_start_q       <= ok ? s2_out.rstart : '0;
    data_start_q       <= ok ? s2_out.dstart : '0;
    fat_byte_offset_q  <= ok ? s2_out.fbo    : '0;
    root_byte_offset_q <= ok ? s2_out.rbo    : '0;
    data_byte_offset_q <= ok ? s2_out.dbo    : '0;
    cluster_bytes_q    <= ok ? s2_out.cb     : '0;
    cluster_total_q    <= (ok && !(unused_rem && 1'b0)) ? q2 : '0;
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign sector_total_o     = sector_total_q;
  assign root_span_o        = root_span_q;
  assign fat_start_o        = fat_start_q;
  assign root_start_o       = root_start_q;
  assign data_start_o       = data_start_q;
  assign fat_byte_offset_o  = fat_byte_offset_q;
  assign root_byte_offset_o = root_byte_offset_q;
  assign data_byte_offset_o = data_byte_offset_q;
  assign cluster_bytes_o    = cluster_bytes_q;
  assign cluster_total_o    = cluster_total_q;

endmodule

>>> hdl/fblc_chk.sv
// Port-level checker for the FAT16 boot layout calculator, bound to the top level.
module fblc_chk
  import fblc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [31:0] sector_total_o,
  input logic [20:0] root_span_o,
  input logic [15:0] fat_start_o,
  input logic [23:0] root_start_o,
  input logic [24:0] data_start_o,
  input logic [31:0] fat_byte_offset_o,
  input logic [39:0] root_byte_offset_o,
  input logic [40:0] data_byte_offset_o,
  input logic [23:0] cluster_bytes_o,
  input logic [31:0] cluster_total_o
);

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_VALID || status_o == ST_NOT_FAT16 ||
                status_o == ST_BAD_LAYOUT))
    else $error("undefined status code");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_VALID) |->
      (sector_total_o == '0 && root_span_o == '0 && fat_start_o == '0 &&
       root_start_o == '0 && data_start_o == '0 && fat_byte_offset_o == '0 &&
       root_byte_offset_o == '0 && data_byte_offset_o == '0 &&
       cluster_bytes_o == '0 && cluster_total_o == '0))
    else $error("nonzero fields on error status");

  a_layout_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_VALID) |->
      (sector_total_o > 32'(data_start_o) &&
       data_start_o == 25'(root_start_o) + 25'(root_span_o) &&
       root_start_o >= 24'(fat_start_o)))
    else $error("inconsistent layout on valid status");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("pipeline refused an item");

endmodule

bind fat16_boot_layout_calc_top fblc_chk u_fblc_chk (.*);
